/* hdl/bprs_pkg.sv */
// Package for the bitmap priority ready scheduler: widths, codes, types.
package bprs_pkg;
    localparam int NUM_LEVELS_DEF  = 32;
    localparam int NUM_THREADS_DEF = 64;
    localparam int CMD_W = 2;
    localparam int TID_W = 6;
    localparam int PRI_W = 5;
    localparam int ERR_W = 2;

    localparam logic [CMD_W-1:0] CMD_READY   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_UNREADY = 2'd1;
    localparam logic [CMD_W-1:0] CMD_SELECT  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_SETPRI  = 2'd3;

    localparam logic [ERR_W-1:0] ERR_OK    = 2'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY = 2'd1;
    localparam logic [ERR_W-1:0] ERR_STATE = 2'd2;

    // result of the priority encoder
    typedef struct packed {
        logic [PRI_W-1:0] level;
        logic             none;
    } t_hi;
endpackage

/* hdl/bitmap_priority_ready_scheduler_unit.sv */
// Top level of the bitmap priority ready scheduler with its command sequencer.
// Each request walks the sequencer states; a bad thread id takes the shortest path (straight to the
// result), a select that pushes back the running thread and then pops takes the longest.
// Throughput: one request at a time; o_ready returns the cycle after the result is taken.
// Reset (synchronous, active low) clears the bitmap, ready marks, level-written marks and
// current thread; the link memories need no clearing.
module bitmap_priority_ready_scheduler_unit #(
    parameter int NUM_LEVELS  = bprs_pkg::NUM_LEVELS_DEF,
    parameter int NUM_THREADS = bprs_pkg::NUM_THREADS_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic [bprs_pkg::CMD_W-1:0]  i_cmd,
    input  logic [bprs_pkg::TID_W-1:0]  i_thread_id,
    input  logic [bprs_pkg::PRI_W-1:0]  i_new_priority,
    input  logic                        i_current_running,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [bprs_pkg::TID_W-1:0]  o_chosen_thread,
    output logic                        o_switched,
    output logic                        o_preempted,
    output logic                        o_reschedule_needed,
    output logic [bprs_pkg::PRI_W-1:0]  o_highest_ready,
    output logic                        o_none_ready,
    output logic [bprs_pkg::ERR_W-1:0]  o_error
);
    localparam int LW = $clog2(NUM_LEVELS);
    localparam int TW = $clog2(NUM_THREADS);
    localparam int TID_W = bprs_pkg::TID_W;
    localparam int PRI_W = bprs_pkg::PRI_W;

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DEC  = 4'd1;  // decode, start op
    localparam logic [3:0] S_UL0  = 4'd2;  // unlink: read head/tail/links
    localparam logic [3:0] S_UL1  = 4'd3;  // unlink: write
    localparam logic [3:0] S_AP0  = 4'd4;  // append/insert
    localparam logic [3:0] S_POP  = 4'd5;  // select pop head
    localparam logic [3:0] S_FIN  = 4'd6;  // compose result
    localparam logic [3:0] S_OUT  = 4'd7;

    // storage
    logic [TID_W-1:0] r_head [NUM_LEVELS];
    logic [TID_W-1:0] r_tail [NUM_LEVELS];
    logic [TID_W-1:0] r_next [NUM_THREADS];
    logic [TID_W-1:0] r_prev [NUM_THREADS];
    logic [LW-1:0]    r_tlev [NUM_THREADS];
    logic [NUM_THREADS-1:0] r_tlv;   // level entry written since reset
    logic [NUM_THREADS-1:0] r_isrdy;
    logic [NUM_LEVELS-1:0]  r_bits;
    logic [TID_W-1:0] r_cur;
    logic [LW-1:0]    r_curlev;      // level of the current thread
    logic             r_curv;

    // request / op context
    logic [3:0]       r_st;
    logic [1:0]       r_cmd;
    logic [TID_W-1:0] r_tid;
    logic [LW-1:0]    r_lvl;
    logic [LW-1:0]    r_tl;    // stored level of the request's thread
    logic             r_run;
    logic [TID_W-1:0] r_ot;    // thread being operated
    logic [LW-1:0]    r_ol;    // level being operated
    logic             r_athead; // insert at head instead of tail
    logic             r_pop;   // pop pending after current op
    logic             r_app;   // append pending after unlink
    logic             r_sw, r_pre;
    logic [1:0]       r_err;
    logic             r_runaft;

    bprs_pkg::t_hi w_hi;
    bprs_prienc #(.NUM_LEVELS(NUM_LEVELS)) u_enc (.i_bits(r_bits), .o_hi(w_hi));

    logic [LW-1:0] w_hil;
    logic [TW-1:0] w_oti;
    logic [LW-1:0] w_reqlvl;
    logic          w_tidok;
    assign w_hil    = LW'(w_hi.level);
    assign w_oti    = TW'(r_ot);
    assign w_tidok  = ({26'd0, i_thread_id} < 32'(NUM_THREADS));
    assign w_reqlvl = ({27'd0, i_new_priority} >= 32'(NUM_LEVELS)) ?
                      LW'(NUM_LEVELS - 1) : LW'(i_new_priority);

    logic [TID_W-1:0] r_h, r_t, r_n, r_p;
    assign o_ready = (r_st == S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_IDLE;
            r_bits   <= '0;
            r_isrdy  <= '0;
            r_tlv    <= '0;
            r_cur    <= '0;
            r_curlev <= '0;
            r_curv   <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            unique case (r_st)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd <= i_cmd;
                        r_tid <= i_thread_id;
                        r_lvl <= w_reqlvl;
                        // registered read of the thread's level, zero until written
                        r_tl  <= r_tlv[TW'(i_thread_id)] ? r_tlev[TW'(i_thread_id)] : '0;
                        r_run <= i_current_running;
                        r_sw  <= 1'b0;
                        r_pre <= 1'b0;
                        r_err <= (!w_tidok && i_cmd != bprs_pkg::CMD_SELECT) ?
                                 bprs_pkg::ERR_STATE : bprs_pkg::ERR_OK;
                        r_pop <= 1'b0;
                        r_app <= 1'b0;
                        r_athead <= 1'b0;
                        r_runaft <= i_current_running;
                        r_st  <= w_tidok || i_cmd == bprs_pkg::CMD_SELECT ? S_DEC : S_FIN;
                    end
                end
                S_DEC: begin
                    unique case (r_cmd)
                        bprs_pkg::CMD_READY: begin
                            if (r_isrdy[TW'(r_tid)]) begin
                                r_err <= bprs_pkg::ERR_STATE;
                                r_st  <= S_FIN;
                            end else begin
                                r_tlev[TW'(r_tid)] <= r_lvl;
                                r_tlv[TW'(r_tid)]  <= 1'b1;
                                if (r_tid == r_cur) begin
                                    r_curlev <= r_lvl;
                                end
                                r_ot <= r_tid;
                                r_ol <= r_lvl;
                                r_st <= S_AP0;
                            end
                        end
                        bprs_pkg::CMD_UNREADY: begin
                            if (!r_isrdy[TW'(r_tid)]) begin
                                r_err <= bprs_pkg::ERR_STATE;
                                r_st  <= S_FIN;
                            end else begin
                                r_ot <= r_tid;
                                r_ol <= r_tl;
                                r_st <= S_UL0;
                            end
                        end
                        bprs_pkg::CMD_SETPRI: begin
                            if (r_tl != r_lvl && r_isrdy[TW'(r_tid)]) begin
                                r_ot  <= r_tid;
                                r_ol  <= r_tl;
                                r_app <= 1'b1;
                                r_st  <= S_UL0;
                            end else begin
                                if (r_tl != r_lvl) begin
                                    r_tlev[TW'(r_tid)] <= r_lvl;
                                    r_tlv[TW'(r_tid)]  <= 1'b1;
                                    if (r_tid == r_cur) begin
                                        r_curlev <= r_lvl;
                                    end
                                end
                                r_st <= S_FIN;
                            end
                        end
                        default: begin  // select
                            if (r_curv && r_run) begin
                                r_runaft <= 1'b1;
                                if (!w_hi.none && w_hil > r_curlev) begin
                                    r_pop <= 1'b1;
                                    if (!r_isrdy[TW'(r_cur)]) begin
                                        r_pre    <= 1'b1;
                                        r_ot     <= r_cur;
                                        r_ol     <= r_curlev;
                                        r_athead <= 1'b1;
                                        r_st     <= S_AP0;
                                    end else begin
                                        r_st <= S_POP;
                                    end
                                end else begin
                                    r_st <= S_FIN;
                                end
                            end else if (w_hi.none) begin
                                // running flag from the request stays as taken
                                r_err <= bprs_pkg::ERR_EMPTY;
                                r_st  <= S_FIN;
                            end else begin
                                r_runaft <= 1'b1;
                                r_pop    <= 1'b1;
                                r_st     <= S_POP;
                            end
                        end
                    endcase
                end
                S_POP: begin
                    // head of highest level becomes the unlink target
                    r_ot  <= r_head[w_hil];
                    r_ol  <= w_hil;
                    r_cur <= r_head[w_hil];
                    r_curlev <= w_hil;
                    r_curv <= 1'b1;
                    r_sw  <= 1'b1;
                    r_pop <= 1'b0;
                    r_st  <= S_UL0;
                end
                S_UL0: begin
                    r_h  <= r_head[r_ol];
                    r_t  <= r_tail[r_ol];
                    r_n  <= r_next[w_oti];
                    r_p  <= r_prev[w_oti];
                    r_st <= S_UL1;
                end
                S_UL1: begin
                    if (r_h == r_ot && r_t == r_ot) begin
                        r_bits[r_ol] <= 1'b0;
                    end else if (r_h == r_ot) begin
                        r_head[r_ol] <= r_n;
                    end else if (r_t == r_ot) begin
                        r_tail[r_ol] <= r_p;
                    end else begin
                        r_next[TW'(r_p)] <= r_n;
                        r_prev[TW'(r_n)] <= r_p;
                    end
                    r_isrdy[w_oti] <= 1'b0;
                    if (r_app) begin
                        r_app <= 1'b0;
                        r_tlev[w_oti] <= r_lvl;
                        r_tlv[w_oti]  <= 1'b1;
                        if (r_ot == r_cur) begin
                            r_curlev <= r_lvl;
                        end
                        r_ol  <= r_lvl;
                        r_st  <= S_AP0;
                    end else begin
                        r_st <= S_FIN;
                    end
                end
                S_AP0: begin
                    if (!r_bits[r_ol]) begin
                        r_head[r_ol] <= r_ot;
                        r_tail[r_ol] <= r_ot;
                        r_bits[r_ol] <= 1'b1;
                    end else if (r_athead) begin
                        r_prev[TW'(r_head[r_ol])] <= r_ot;
                        r_next[w_oti] <= r_head[r_ol];
                        r_head[r_ol] <= r_ot;
                    end else begin
                        r_next[TW'(r_tail[r_ol])] <= r_ot;
                        r_prev[w_oti] <= r_tail[r_ol];
                        r_tail[r_ol] <= r_ot;
                    end
                    r_isrdy[w_oti] <= 1'b1;
                    r_athead <= 1'b0;
                    r_st <= r_pop ? S_POP : S_FIN;
                end
                S_FIN: begin
                    o_chosen_thread <= r_cur;
                    o_switched      <= r_sw;
                    o_preempted     <= r_pre;
                    o_reschedule_needed <= !r_curv || !r_runaft ||
                        (!w_hi.none && w_hil > r_curlev);
                    o_highest_ready <= w_hi.level;
                    o_none_ready    <= w_hi.none;
                    o_error         <= r_err;
                    o_valid         <= 1'b1;
                    r_st            <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) begin
                        o_valid <= 1'b0;
                        r_st    <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/bprs_prienc.sv */
// Highest-set-bit encoder over the ready bitmap.
module bprs_prienc #(
    parameter int NUM_LEVELS = bprs_pkg::NUM_LEVELS_DEF
) (
    input  logic [NUM_LEVELS-1:0] i_bits,
    output bprs_pkg::t_hi         o_hi
);
    localparam int LW = $clog2(NUM_LEVELS);
    logic [LW-1:0] w_idx;

    // scan upward, last set bit wins
    always_comb begin
        w_idx = '0;
        for (int i = 0; i < NUM_LEVELS; i++) begin
            if (i_bits[i]) begin
                w_idx = LW'(i);
            end
        end
        o_hi.level = bprs_pkg::PRI_W'(w_idx);
        o_hi.none  = (i_bits == '0);
    end
endmodule
